// File: src/box_blur_3x3_edge_normalized_unit_defines.svh
// ============================================================================
// Box blur assertion macros
// Shared concurrent assertion forms for the box blur checker.
// ============================================================================
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BB_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bblur3_pkg.sv
// ============================================================================
// Box blur package
// Types, field widths, register codes and the reciprocal table of the blur.
// ============================================================================
package bblur3_pkg;

    localparam int PIX_W      = 8;
    localparam int PIXEL_W    = 3 * PIX_W;
    localparam int TDATA_W    = 24;
    localparam int WIN_N      = 9;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int X_W        = 13;
    localparam int RECIP_W    = 20;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W     = 33;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_H_W-1:0] RESET_HEIGHT = 13'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic             frame_end;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_result;

    typedef struct packed {
        logic             sum_en;
        logic             mul_en;
        logic [WIN_N-1:0] mask;
        logic [CNT_W-1:0] count;
    } t_lane_ctl;

    // Reciprocal of twice the pixel count, scaled by two to the RECIP_SHIFT.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] val;
        case (cnt)
            4'd2:    val = 20'd262144;
            4'd3:    val = 20'd174763;
            4'd4:    val = 20'd131072;
            4'd5:    val = 20'd104858;
            4'd6:    val = 20'd87382;
            4'd7:    val = 20'd74899;
            4'd8:    val = 20'd65536;
            4'd9:    val = 20'd58255;
            default: val = 20'd524288;
        endcase
        return val;
    endfunction

endpackage

// File: src/box_blur_3x3_edge_normalized_unit.sv
// ============================================================================
// 3x3 box blur with edge normalization
// Per-channel mean over the in-image part of each pixel's 3x3 neighborhood.
// ============================================================================
// Pixels enter in raster order on the s_axis channel; tuser low carries a
// pixel, tuser high drains one pending result once the frame's pixels are in.
// Results leave on m_axis, tlast marking the frame's last pixel. A result
// for pixel (r,c) comes out with the transaction that carries pixel
// (r+1,c+1), so image_width+1 drains flush a frame.
// Image width and height are written on the cfg channel while the block is
// idle; a write restarts the frame position.
// A transaction that yields a result passes in turn through a read of the
// combined line store, the window shift, the lane adder trees, the reciprocal
// multiply and the load of the output register. A transaction without a
// result ends after the window shift, and an early drain is only accepted.
// The output register holds one result, so the next transaction is accepted
// while it waits; when the receiver stalls, the block stops at its output
// step. Reset is synchronous and restores 640x480 with the frame position at
// zero; no clearing pass is needed.
// ============================================================================
module box_blur_3x3_edge_normalized_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bblur3_pkg::TDATA_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                                s_axis_tuser,  // operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bblur3_pkg::TDATA_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bblur3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bblur3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bblur3_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 2);
    localparam int ORW    = $clog2(MAX_HEIGHT);
    localparam int LINE_W = 2 * PIXEL_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [WW-1:0]      eff_w;
    logic [HW-1:0]      eff_h;
    logic [CW-1:0]      r_in_col;
    logic [RW-1:0]      r_in_row;
    logic [CW-1:0]      r_out_col;
    logic [ORW-1:0]     r_out_row;
    logic               r_emit;
    t_pixel             r_pixel;
    logic [LINE_W-1:0]  r_mem_q;
    logic [LINE_W-1:0]  line_mem [MAX_WIDTH];
    t_pixel             r_win [WIN_N];

    logic               in_acc;
    logic               cfg_acc;
    logic               cfg_hit;
    logic               past;
    logic               drop;
    logic               emit;
    logic [WW-1:0]      col_inc;
    logic               last;
    logic               out_free;
    logic               out_load;
    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    logic [WIN_N-1:0]   mask;
    t_lane_ctl          lane_ctl;
    t_result            result;
    t_pixel             in_pixel;
    logic [WIN_N-1:0][PIX_W-1:0] red_px;
    logic [WIN_N-1:0][PIX_W-1:0] green_px;
    logic [WIN_N-1:0][PIX_W-1:0] blue_px;
    logic [PIX_W-1:0]   red_avg;
    logic [PIX_W-1:0]   green_avg;
    logic [PIX_W-1:0]   blue_avg;

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_h);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign cfg_hit       = cfg_acc && ((i_cfg_index == REG_IMAGE_WIDTH) ||
                                       (i_cfg_index == REG_IMAGE_HEIGHT));

    assign past    = r_in_row >= RW'(eff_h);
    assign drop    = !past && (s_axis_tuser == OP_DRAIN);
    assign emit    = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign col_inc = WW'(r_in_col) + WW'(1);

    assign in_pixel.red   = s_axis_tdata[PIX_W-1:0];
    assign in_pixel.green = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign in_pixel.blue  = s_axis_tdata[3*PIX_W-1:2*PIX_W];

    assign last = (HW'(r_out_row) == eff_h - HW'(1)) && (WW'(r_out_col) == eff_w - WW'(1));

    // Window row k and column i hold output row + k - 1 and output column + i - 1.
    assign row_ok[0] = (r_out_row != '0);
    assign row_ok[1] = 1'b1;
    assign row_ok[2] = (HW'(r_out_row) + HW'(1)) < eff_h;
    assign col_ok[0] = (r_out_col != '0);
    assign col_ok[1] = 1'b1;
    assign col_ok[2] = (WW'(r_out_col) + WW'(1)) < eff_w;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                mask[k*3 + i] = row_ok[k] && col_ok[i];
            end
        end
    end

    assign lane_ctl.sum_en = (r_state == ST_SUM);
    assign lane_ctl.mul_en = (r_state == ST_MUL);
    assign lane_ctl.mask   = mask;
    assign lane_ctl.count  = CNT_W'($countones(mask));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && !drop) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_state = r_emit ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign out_load = (r_state == ST_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg_w   <= RESET_WIDTH;
            r_cfg_h   <= RESET_HEIGHT;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_emit    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: begin
                        r_cfg_w <= i_cfg_data[CFG_W_W-1:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        r_cfg_h <= i_cfg_data[CFG_H_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_acc && !drop) begin
                r_emit <= emit;
            end
            if (cfg_hit || (out_load && last)) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (r_state == ST_SHIFT) begin
                if (col_inc >= eff_w) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RW'(1);
                end else begin
                    r_in_col <= CW'(col_inc);
                end
            end else if (out_load) begin
                if ((WW'(r_out_col) + WW'(1)) >= eff_w) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ORW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // Each line store entry keeps the row two back above the row one back.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q <= line_mem[r_in_col];
        end
        if (r_state == ST_SHIFT) begin
            line_mem[r_in_col] <= {r_mem_q[PIXEL_W-1:0], r_pixel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !drop) begin
            r_pixel <= past ? t_pixel'('0) : in_pixel;
        end
        if (r_state == ST_SHIFT) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3 + 0] <= r_win[k*3 + 1];
                r_win[k*3 + 1] <= r_win[k*3 + 2];
            end
            r_win[2] <= t_pixel'(r_mem_q[LINE_W-1:PIXEL_W]);
            r_win[5] <= t_pixel'(r_mem_q[PIXEL_W-1:0]);
            r_win[8] <= r_pixel;
        end
    end

    always_comb begin
        for (int k = 0; k < WIN_N; k++) begin
            red_px[k]   = r_win[k].red;
            green_px[k] = r_win[k].green;
            blue_px[k]  = r_win[k].blue;
        end
    end

    bblur3_lane u_lane_red (
        .i_clk (i_clk),
        .i_ctl (lane_ctl),
        .i_px  (red_px),
        .o_avg (red_avg)
    );

    bblur3_lane u_lane_green (
        .i_clk (i_clk),
        .i_ctl (lane_ctl),
        .i_px  (green_px),
        .o_avg (green_avg)
    );

    bblur3_lane u_lane_blue (
        .i_clk (i_clk),
        .i_ctl (lane_ctl),
        .i_px  (blue_px),
        .o_avg (blue_avg)
    );

    assign result.red       = red_avg;
    assign result.green     = green_avg;
    assign result.blue      = blue_avg;
    assign result.frame_end = last;

    bblur3_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (result),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// File: src/bblur3_lane.sv
// ============================================================================
// Box blur channel lane
// Sums the selected window samples of one channel and divides by the count.
// ============================================================================
module bblur3_lane (
    input  logic                                            i_clk,
    input  bblur3_pkg::t_lane_ctl                           i_ctl,
    input  logic [bblur3_pkg::WIN_N-1:0][bblur3_pkg::PIX_W-1:0] i_px,
    output logic [bblur3_pkg::PIX_W-1:0]                    o_avg
);
    import bblur3_pkg::*;

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [X_W-1:0]    dividend;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < WIN_N; k++) begin
            if (i_ctl.mask[k]) begin
                n_sum = n_sum + SUM_W'(i_px[k]);
            end
        end
    end

    // Rounding half up: (2 * sum + n) / (2 * n).
    assign dividend = {r_sum, 1'b0} + X_W'(i_ctl.count);
    assign n_prod   = PROD_W'(dividend) * PROD_W'(recip(i_ctl.count));

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
        if (i_ctl.mul_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_avg = r_prod[RECIP_SHIFT +: PIX_W];

endmodule

// File: src/bblur3_out.sv
// ============================================================================
// Box blur output stage
// Merges the three lane results into one output register on the stream.
// ============================================================================
module bblur3_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  bblur3_pkg::t_result                i_result,
    output logic                               o_free,
    output logic                               o_tvalid,
    input  logic                               i_tready,
    output logic [bblur3_pkg::TDATA_W-1:0]     o_tdata,
    output logic                               o_tlast
);
    import bblur3_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_result.blue, r_result.green, r_result.red};
    assign o_tlast  = r_result.frame_end;

endmodule

// File: src/bblur3_chk.sv
// ============================================================================
// Box blur port checker
// Watches the top-level ports of the box blur and flags illegal sequences.
// ============================================================================
`include "box_blur_3x3_edge_normalized_unit_defines.svh"

module bblur3_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [bblur3_pkg::TDATA_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input logic                                s_axis_tuser,  // operation
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [bblur3_pkg::TDATA_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
    input logic                                m_axis_tlast,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [bblur3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [bblur3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bblur3_pkg::*;

    `BB_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")

    `BB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")

    `BB_ASSERT_NEXT(a_pixel_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PIXEL), !s_axis_tready && !o_cfg_ready, "ready right after a pixel transaction")

    `BB_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared while idle")

    `BB_ASSERT_SAME(a_ready_pair, i_clk, i_rst_n, o_cfg_ready && !i_cfg_valid, s_axis_tready, "input not ready while idle")

endmodule

bind box_blur_3x3_edge_normalized_unit bblur3_chk u_bblur3_chk (.*);

// File: test/box_blur_3x3_edge_normalized_unit_checker.sv
// ============================================================================
// Box blur stream checker
// Watches the pixel, result and register channels of the 3x3 box blur. Every
// accepted pixel, and every drain once the frame's pixels are in, advances a
// cycle-free model of the blur (line stores, 3x3 window, frame position), and
// every result it owes is queued. Each accepted result is compared field by
// field with the oldest queued one. The failure count and the number of owed results go to the top.
// ============================================================================
module box_blur_3x3_edge_normalized_unit_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [bblur3_pkg::TDATA_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                                s_axis_tuser,  // operation
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bblur3_pkg::TDATA_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
    input  logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [bblur3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bblur3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                  o_error_count,
    output int                                  o_pending_count
);
    import bblur3_pkg::*;

    t_pixel             line_prev  [MAX_WIDTH];
    t_pixel             line_older [MAX_WIDTH];
    t_pixel             window     [9];
    int                 in_col;
    int                 in_row;
    int                 out_col;
    int                 out_row;
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    t_result            owed_blurs [$];
    int                 errors = 0;

    function automatic int active_width();
        if (width_reg < 1) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg < 1) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic void restart_positions();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // The window column cc holds the output column; window row 1 the output row.
    function automatic t_result window_mean(input int cc, input int w, input int h);
        t_result res;
        int      sum_r = 0;
        int      sum_g = 0;
        int      sum_b = 0;
        int      n = 0;
        int      row;
        int      col;
        int      idx;
        for (int k = 0; k < 3; k++) begin
            row = out_row + k - 1;
            if (row >= 0 && row < h) begin
                for (int j = -1; j <= 1; j++) begin
                    col = out_col + j;
                    idx = cc + j;
                    if (col >= 0 && col < w && idx >= 0 && idx <= 2) begin
                        sum_r += int'(window[k * 3 + idx].red);
                        sum_g += int'(window[k * 3 + idx].green);
                        sum_b += int'(window[k * 3 + idx].blue);
                        n++;
                    end
                end
            end
        end
        if (n == 0) n = 1;
        res.red       = 8'((2 * sum_r + n) / (2 * n));
        res.green     = 8'((2 * sum_g + n) / (2 * n));
        res.blue      = 8'((2 * sum_b + n) / (2 * n));
        res.frame_end = 1'b0;
        return res;
    endfunction

    function automatic bit blur_step(input logic op, input logic [TDATA_W-1:0] data,
                                     output t_result res);
        int     w;
        int     h;
        int     r;
        int     c;
        int     col;
        bit     past;
        bit     emit;
        bit     last;
        t_pixel px;
        w    = active_width();
        h    = active_height();
        past = (in_row >= h);
        res  = '0;
        if (!past && op == OP_DRAIN) return 1'b0;
        px.red   = data[7:0];
        px.green = data[15:8];
        px.blue  = data[23:16];
        if (past) px = '0;
        r    = in_row;
        c    = in_col;
        emit = (r >= 2) || (r == 1 && c >= 1);
        if (emit && c == 0) res = window_mean(2, w, h);
        col = c % MAX_WIDTH;
        for (int k = 0; k < 3; k++) begin
            window[k * 3]     = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2]       = line_older[col];
        window[5]       = line_prev[col];
        window[8]       = px;
        line_older[col] = line_prev[col];
        line_prev[col]  = px;
        if (emit && c != 0) res = window_mean(1, w, h);
        in_col = c + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = r + 1;
        end
        if (!emit) return 1'b0;
        last = (out_row == h - 1) && (out_col == w - 1);
        res.frame_end = last;
        if (last) begin
            restart_positions();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                line_prev[i]  = '0;
                line_older[i] = '0;
            end
            for (int i = 0; i < 9; i++) begin
                window[i] = '0;
            end
            restart_positions();
            owed_blurs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[CFG_W_W-1:0];
                        restart_positions();
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data[CFG_H_W-1:0];
                        restart_positions();
                    end
                    default: begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_blurs.size() == 0) begin
                    errors++;
                    $error("result with nothing owed: tdata %h, tlast %0d",
                           m_axis_tdata, m_axis_tlast);
                end else begin
                    want = owed_blurs.pop_front();
                    check_field("red_out", int'(want.red), int'(m_axis_tdata[7:0]));
                    check_field("green_out", int'(want.green), int'(m_axis_tdata[15:8]));
                    check_field("blue_out", int'(want.blue), int'(m_axis_tdata[23:16]));
                    check_field("frame_end", int'(want.frame_end), int'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (blur_step(s_axis_tuser, s_axis_tdata, want)) owed_blurs.push_back(want);
            end
        end
        o_error_count   <= errors;
        o_pending_count <= owed_blurs.size();
    end

endmodule

// File: test/box_blur_3x3_edge_normalized_unit_tb.sv
// ============================================================================
// Box blur testbench
// Drives the 3x3 box blur with directed frames (one pixel, checkerboard,
// single row, early drains, extra pixels, spare register indexes), then with
// random frames of random size, some noisy or abandoned, under three idling
// mixes and one long receiver stall, and last with part of a frame whose
// width and height lie above the maximum.
// ============================================================================
module box_blur_3x3_edge_normalized_unit_tb;
    import bblur3_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 180;
    localparam int WIDE_CUT      = 1030;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef logic [TDATA_W-1:0]    t_word;
    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    t_word                 s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_PIXEL;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    t_word                 m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = REG_IMAGE_WIDTH;
    t_cfg_word             i_cfg_data    = '0;

    int error_count;
    int pending_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int cur_w         = 640;
    int cur_h         = 480;
    int stream_items  = 0;
    int cycle_count   = 0;

    box_blur_3x3_edge_normalized_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    box_blur_3x3_edge_normalized_unit_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** box_blur_3x3_edge_normalized_unit: FAILED **");
            $finish;
        end
    end

    // A long hold keeps tready low so that the block fills up behind it.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_served++;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic int width_of(input t_cfg_word word);
        if (word[CFG_W_W-1:0] < 1) return 1;
        if (word[CFG_W_W-1:0] > MAX_WIDTH) return MAX_WIDTH;
        return int'(word[CFG_W_W-1:0]);
    endfunction

    function automatic int height_of(input t_cfg_word word);
        if (word < 1) return 1;
        if (word > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(word);
    endfunction

    function automatic t_word rand_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_cfg_word random_width_word();
        logic [CFG_W_W-1:0] w;
        case ($urandom_range(9))
            0:       w = '0;
            1:       w = CFG_W_W'($urandom_range(40, 11));
            default: w = CFG_W_W'($urandom_range(10, 1));
        endcase
        return {2'($urandom), w};
    endfunction

    function automatic t_cfg_word random_height_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return t_cfg_word'($urandom_range(12, 7));
            default: return t_cfg_word'($urandom_range(6, 1));
        endcase
    endfunction

    // Every task starts and ends at a falling edge.
    task automatic send_item(input logic op, input t_word data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input t_cfg_word word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_size(input t_cfg_word w_word, input t_cfg_word h_word);
        wait_idle();
        write_register(REG_IMAGE_WIDTH, w_word);
        write_register(REG_IMAGE_HEIGHT, h_word);
        cur_w = width_of(w_word);
        cur_h = height_of(h_word);
    endtask

    // A noisy frame carries ignored early drains, pixels in place of drains
    // and a stray drain after the frame end. A frame cut short stops at cut.
    task automatic send_frame(input int cut, input bit noisy, input bit checkerboard);
        logic [7:0] chk;
        t_word      px;
        for (int i = 0; i < cur_w * cur_h; i++) begin
            if (i == cut) return;
            if (noisy && $urandom_range(7) == 0) send_item(OP_DRAIN, t_word'($urandom));
            chk = ((i % 2) == 1) ? 8'hFF : 8'h00;
            px  = checkerboard ? {8'($urandom), ~chk, chk} : rand_pixel();
            send_item(OP_PIXEL, px);
            stream_items++;
        end
        for (int i = 0; i <= cur_w; i++) begin
            if (noisy && $urandom_range(3) == 0) begin
                send_item(OP_PIXEL, t_word'($urandom));
            end else begin
                send_item(OP_DRAIN, t_word'($urandom));
            end
            stream_items++;
        end
        if (noisy) send_item(OP_DRAIN, t_word'($urandom));
    endtask

    task automatic random_traffic(input int quota);
        int goal;
        int kind;
        int cut;
        goal = stream_items + quota;
        while (stream_items < goal) begin
            kind = $urandom_range(9);
            if (kind <= 5 || kind == 7 || kind == 8) begin
                set_size(random_width_word(), random_height_word());
            end
            if (kind == 9) begin
                wait_idle();
                write_register(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                               t_cfg_word'($urandom));
            end
            if (kind == 8) begin
                cut = $urandom_range(cur_w * cur_h - 1);
                send_frame(cut, 1'b0, 1'b0);
                set_size(t_cfg_word'(cur_w), t_cfg_word'(cur_h));
            end else begin
                send_frame(-1, kind == 7, 1'b0);
            end
        end
    endtask

    initial begin
        send_idle_pct = 38;
        recv_idle_pct = 69;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A drain before any frame is complete is ignored.
        send_item(OP_DRAIN, '1);

        // Zero sizes act as one: a single pixel, then a pixel that acts as a
        // drain, a drain, and a stray drain after the frame end.
        set_size('0, '0);
        send_item(OP_PIXEL, '1);
        send_item(OP_PIXEL, '0);
        send_item(OP_DRAIN, t_word'($urandom));
        send_item(OP_DRAIN, t_word'($urandom));

        // Checkerboard values make the rounding land on halves.
        set_size(13'd3, 13'd3);
        send_frame(-1, 1'b1, 1'b1);

        wait_idle();
        write_register(REG_SPARE_A, '1);
        write_register(REG_SPARE_B, t_cfg_word'($urandom));

        // A single row: the first drain yields nothing.
        set_size(13'd2, 13'd1);
        send_frame(-1, 1'b0, 1'b0);

        random_traffic(PHASE_ITEMS);
        send_idle_pct = 69;
        recv_idle_pct = 38;
        random_traffic(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        set_size(13'd8, 13'd6);
        hold_requests++;
        send_frame(-1, 1'b0, 1'b0);
        random_traffic(PHASE_ITEMS);

        // Sizes above the maximum act as the maximum: the row wraps after
        // the largest width, so the first results of the frame appear.
        set_size(13'h7FF, 13'h1FFF);
        send_frame(WIDE_CUT, 1'b0, 1'b0);

        wait_idle();
        if (error_count == 0) begin
            $display("** box_blur_3x3_edge_normalized_unit: PASSED **");
        end else begin
            $display("** box_blur_3x3_edge_normalized_unit: FAILED **");
        end
        $finish;
    end

endmodule
